// File: rtl/growing_core_spring_force_macros.svh
// Assertion macros shared by the spring force block.
`ifndef GROWING_CORE_SPRING_FORCE_MACROS_SVH
`define GROWING_CORE_SPRING_FORCE_MACROS_SVH
`ifndef ASSERT_OFF
`define GCSF_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error("assertion failed");
`define GCSF_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("assertion failed");
`else
`define GCSF_ASSERT_IMP(label, clk, rst_n, pre, post)
`define GCSF_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// File: rtl/gcsf_pkg.sv
package gcsf_pkg;
	localparam int WALL_COUNT_DEF = 1024;
	localparam int DIMENSIONS_DEF = 3;
	localparam logic [1:0] OP_SET = 2'd0;
	localparam logic [1:0] OP_FORCE = 2'd1;
	localparam logic [1:0] OP_GROW = 2'd2;
	localparam logic [0:0] REG_STIFFNESS = 1'b0;
	localparam logic [0:0] REG_GROWTH = 1'b1;
	localparam logic [31:0] STIFF_RESET = 32'h0001_0000;
	localparam logic [31:0] GROWTH_RESET = 32'h4000_0000;
	localparam logic [31:0] LEN_MAX = 32'h7FFF_FFFF;

	typedef struct packed {
		logic [1:0] opcode;
		logic [9:0] wall_index;
		logic bears_flag;
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic signed [31:0] first_z;
		logic signed [31:0] second_x;
		logic signed [31:0] second_y;
		logic signed [31:0] second_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
		logic pushing;
	} out_item_t;
endpackage

// File: rtl/growing_core_spring_force.sv
// Flow from input transfer to result valid: an unsupported opcode goes straight to done;
// set items and force items that make no force pass the serial square, the root and the
// control states, and a force item that pushes also runs the divide and the axis steps.
// Grow reads and rewrites each wall in turn through the core length RAM port.
// One item is in work at a time; the next can be taken in the cycle after its result is loaded.
// After reset a clearing pass zeroes the core lengths before any item.
`include "growing_core_spring_force_macros.svh"
module growing_core_spring_force import gcsf_pkg::*; #(
	parameter int WALL_COUNT = WALL_COUNT_DEF,
	parameter int DIMENSIONS = DIMENSIONS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_data,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [31:0] cfg_data
);
	localparam int AW = (WALL_COUNT > 1) ? $clog2(WALL_COUNT) : 1;
	localparam int RD = (WALL_COUNT > 1) ? WALL_COUNT : 2;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_READ = 4'd2;
	localparam logic [3:0] ST_SQ = 4'd3;
	localparam logic [3:0] ST_SQRT = 4'd4;
	localparam logic [3:0] ST_DIV = 4'd5;
	localparam logic [3:0] ST_AXIS = 4'd6;
	localparam logic [3:0] ST_GROWR = 4'd7;
	localparam logic [3:0] ST_GROWM = 4'd8;
	localparam logic [3:0] ST_DONE = 4'd9;
	localparam logic [3:0] ST_SET = 4'd10;
	localparam logic [3:0] ST_CHECK = 4'd11;

	logic [3:0] state_q;
	logic [31:0] stiff_q, growth_q;
	in_item_t item_q;
	logic [AW:0] cnt_q;
	logic [6:0] step_q;
	logic [1:0] axis_q;
	logic [32:0] mag_q [3];
	logic neg_q [3];
	logic big_q;
	logic [65:0] sum_q;
	logic [65:0] rem_q;
	logic [33:0] root_q;
	logic [31:0] d_q, core_q;
	logic [63:0] num_q;
	logic [63:0] quo_q;
	logic [32:0] drem_q;
	logic [31:0] rdiv_q;
	logic [95:0] acc_q;
	logic [31:0] mcand_q;
	logic [63:0] prod_q;
	logic [63:0] qsh_q;
	logic [63:0] rsh_q;
	logic [31:0] force_q [3];
	logic push_q;

	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0] ram_wdata, ram_rdata;

	gcsf_ram #(.WIDTH(32), .DEPTH(RD)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	logic wall_ok;
	logic done_load;
	assign wall_ok = ({22'd0, item_q.wall_index} < 32'(WALL_COUNT));
	assign in_ready = (state_q == ST_IDLE);
	// The output register loads when it is empty or emptied in the same cycle.
	assign done_load = (state_q == ST_DONE) && (!out_valid || out_ready);

	// Differences of the input item, 33 bits signed.
	logic signed [32:0] dif [3];
	always_comb begin
		dif[0] = 33'(item_q.first_x) - 33'(item_q.second_x);
		dif[1] = 33'(item_q.first_y) - 33'(item_q.second_y);
		dif[2] = 33'(item_q.first_z) - 33'(item_q.second_z);
	end

	// Restoring square root, one result bit a cycle (2 bits of radicand).
	logic [65:0] sq_trial;
	logic [65:0] sq_rem_next;
	assign sq_rem_next = {rem_q[63:0], sum_q[65:64]};
	assign sq_trial = {root_q[31:0], 2'b01};

	// Restoring divider, one quotient bit a cycle.
	logic [32:0] dv_rem;
	assign dv_rem = {drem_q[31:0], num_q[63]};

	// Shift-add multiplier term: acc += mcand if low bit of prod.
	logic [63:0] add_term;
	assign add_term = prod_q[0] ? {32'd0, mcand_q} : 64'd0;

	logic [32:0] ax_mag;
	always_comb begin
		ax_mag = mag_q[axis_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q <= '0;
			out_valid <= 1'b0;
			stiff_q <= STIFF_RESET;
			growth_q <= GROWTH_RESET;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_STIFFNESS) stiff_q <= cfg_data;
				else stiff_q <= stiff_q;
				if (cfg_index == REG_GROWTH) growth_q <= cfg_data;
			end
			if (done_load) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (AW+1)'(WALL_COUNT - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						item_q <= in_data;
						cnt_q <= '0;
						push_q <= 1'b0;
						force_q[0] <= '0;
						force_q[1] <= '0;
						force_q[2] <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					// RAM read of the wall issued; compute magnitudes meanwhile.
					big_q <= 1'b0;
					for (int k = 0; k < 3; k++) begin
						if (k < DIMENSIONS) begin
							mag_q[k] <= dif[k][32] ? 33'(-dif[k]) : 33'(dif[k]);
							neg_q[k] <= dif[k][32];
						end else begin
							mag_q[k] <= '0;
							neg_q[k] <= 1'b0;
						end
					end
					sum_q <= '0;
					axis_q <= '0;
					if (item_q.opcode == OP_GROW) begin
						cnt_q <= '0;
						state_q <= ST_GROWR;
					end else if (item_q.opcode == OP_SET || item_q.opcode == OP_FORCE)
						state_q <= ST_SQ;
					else state_q <= ST_DONE;
					step_q <= '0;
				end
				ST_SQ: begin
					// Serial square of one axis at a time, one multiplier bit per step: a load step, then 32 add steps per axis.
					if (step_q == 7'd0) begin
						core_q <= (item_q.opcode == OP_FORCE && wall_ok) ? ram_rdata : 32'd0;
						prod_q <= {32'd0, ax_mag[31:0]};
						mcand_q <= ax_mag[31:0];
						acc_q <= '0;
						if (ax_mag[32] || ax_mag[31]) big_q <= 1'b1;
						step_q <= 7'd1;
					end else begin
						acc_q <= acc_q + ({32'd0, add_term} << (step_q - 7'd1));
						prod_q <= prod_q >> 1;
						if (step_q == 7'd32) begin
							step_q <= '0;
							if (axis_q == 2'd2) begin
								state_q <= ST_SQRT;
								sum_q <= sum_q + 66'(acc_q + ({32'd0, add_term} << 31));
								rem_q <= '0;
								root_q <= '0;
							end else begin
								sum_q <= sum_q + 66'(acc_q + ({32'd0, add_term} << 31));
								axis_q <= axis_q + 1'b1;
							end
						end else step_q <= step_q + 1'b1;
					end
				end
				ST_SQRT: begin
					if (sq_rem_next >= sq_trial) begin
						rem_q <= sq_rem_next - sq_trial;
						root_q <= {root_q[32:0], 1'b1};
					end else begin
						rem_q <= sq_rem_next;
						root_q <= {root_q[32:0], 1'b0};
					end
					sum_q <= {sum_q[63:0], 2'b00};
					step_q <= step_q + 1'b1;
					if (step_q == 7'd32) begin
						state_q <= ST_CHECK;
						step_q <= '0;
					end
				end
				ST_CHECK: begin
					d_q <= (big_q || root_q[33:31] != 3'd0) ? LEN_MAX : root_q[31:0];
					state_q <= ST_SET;
				end
				ST_SET: begin
					if (item_q.opcode == OP_SET) state_q <= ST_DONE;
					else if (item_q.bears_flag && d_q != 32'd0 && d_q < core_q) begin
						num_q <= 64'(stiff_q) * 64'(core_q - d_q) ;
						drem_q <= '0;
						quo_q <= '0;
						step_q <= '0;
						state_q <= ST_DIV;
					end else state_q <= ST_DONE;
				end
				ST_DIV: begin
					// Quotient and remainder of K*(core-d) by d.
					if (dv_rem >= {1'b0, d_q}) begin
						drem_q <= dv_rem - {1'b0, d_q};
						rdiv_q <= 32'(dv_rem - {1'b0, d_q});
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						drem_q <= dv_rem;
						rdiv_q <= dv_rem[31:0];
						quo_q <= {quo_q[62:0], 1'b0};
					end
					num_q <= num_q << 1;
					step_q <= step_q + 1'b1;
					if (step_q == 7'd63) begin
						step_q <= '0;
						axis_q <= '0;
						state_q <= ST_AXIS;
					end
				end
				ST_AXIS: begin
					// n = q*m + floor(r*m/d): both products are built serially, then
					// r*m < d*2^32 goes through a 64-bit divide.
					if (step_q == 7'd0) begin
						prod_q <= {32'd0, ax_mag[31:0]};
						qsh_q <= quo_q;
						rsh_q <= {32'd0, rdiv_q};
						acc_q <= '0;
						num_q <= '0;
						drem_q <= '0;
						step_q <= 7'd1;
					end else if (step_q <= 7'd32) begin
						if (prod_q[0]) begin
							acc_q <= acc_q + 96'(qsh_q);
							num_q <= num_q + rsh_q;
						end
						prod_q <= prod_q >> 1;
						qsh_q <= qsh_q << 1;
						rsh_q <= rsh_q << 1;
						step_q <= step_q + 1'b1;
					end else if (step_q <= 7'd96) begin
						if (dv_rem >= {1'b0, d_q}) begin
							drem_q <= dv_rem - {1'b0, d_q};
							prod_q <= {prod_q[62:0], 1'b1};
						end else begin
							drem_q <= dv_rem;
							prod_q <= {prod_q[62:0], 1'b0};
						end
						num_q <= num_q << 1;
						step_q <= step_q + 1'b1;
					end else begin
						acc_q <= (acc_q + 96'(prod_q)) >> 16;
						step_q <= '0;
						if (neg_q[axis_q])
							force_q[axis_q] <= (((acc_q + 96'(prod_q)) >> 16) >= 96'h8000_0000)
								? 32'h8000_0000 : 32'(-((acc_q + 96'(prod_q)) >> 16));
						else
							force_q[axis_q] <= (((acc_q + 96'(prod_q)) >> 16) > 96'(LEN_MAX))
								? LEN_MAX : 32'((acc_q + 96'(prod_q)) >> 16);
						if (axis_q == 2'd2) begin
							push_q <= 1'b1;
							state_q <= ST_DONE;
						end else axis_q <= axis_q + 1'b1;
					end
				end
				ST_GROWR: begin
					state_q <= ST_GROWM;
				end
				ST_GROWM: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (AW+1)'(WALL_COUNT - 1)) state_q <= ST_DONE;
					else state_q <= ST_GROWR;
				end
				ST_DONE: begin
					if (done_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (done_load) begin
			out_data.force_x <= (DIMENSIONS > 0) ? force_q[0] : 32'd0;
			out_data.force_y <= (DIMENSIONS > 1) ? force_q[1] : 32'd0;
			out_data.force_z <= (DIMENSIONS > 2) ? force_q[2] : 32'd0;
			out_data.pushing <= push_q;
		end
	end

	logic [63:0] grow_prod;
	assign grow_prod = 64'(ram_rdata) * 64'(growth_q);

	always_comb begin
		ram_raddr = AW'(item_q.wall_index);
		ram_we = 1'b0;
		ram_waddr = cnt_q[AW-1:0];
		ram_wdata = 32'd0;
		case (state_q)
			ST_IDLE: ram_raddr = AW'(in_data.wall_index);
			ST_CLEAR: ram_we = 1'b1;
			ST_GROWR: ram_raddr = cnt_q[AW-1:0];
			ST_GROWM: begin
				ram_raddr = cnt_q[AW-1:0];
				ram_we = 1'b1;
				ram_wdata = (grow_prod[63:61] != 3'd0) ? LEN_MAX : grow_prod[61:30];
			end
			ST_SET: begin
				ram_waddr = AW'(item_q.wall_index);
				ram_we = (item_q.opcode == OP_SET) && wall_ok;
				ram_wdata = item_q.bears_flag ? d_q : 32'd0;
			end
			default: ram_raddr = AW'(item_q.wall_index);
		endcase
	end

	logic unused_ok;
	assign unused_ok = ^{drem_q[32], sq_rem_next[65], acc_q[95]};

	`GCSF_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ready, state_q == ST_IDLE)
	`GCSF_ASSERT_NEXT(a_done_valid, clk, arst_n, state_q == ST_DONE, out_valid)
	`GCSF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

// File: rtl/gcsf_ram.sv
module gcsf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
